@@ design/nxp_pkg.sv @@
// Package for the next-permutation generator: widths, length bounds, request
// kind codes and the memory request struct. No dependencies.
`timescale 1ns / 1ps

package nxp_pkg;

    localparam int MAX_LEN = 16;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int POS_W   = 4;
    localparam int VAL_W   = 8;
    localparam int LEN_W   = 5;

    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [VAL_W-1:0] t_val;

    typedef struct packed {
        logic we;
        t_idx waddr;
        t_val wdata;
        t_idx raddr_a;
        t_idx raddr_b;
    } t_mem_req;

endpackage

@@ design/nxp_store.sv @@
// Sequence store: one write port, two registered read ports.
// Entries read as their own index until first written. Uses nxp_pkg.
`timescale 1ns / 1ps

module nxp_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nxp_pkg::t_mem_req i_req,
    output nxp_pkg::t_val     o_rd_a,
    output nxp_pkg::t_val     o_rd_b
);

    nxp_pkg::t_val              r_mem [nxp_pkg::MAX_LEN];
    logic [nxp_pkg::MAX_LEN-1:0] r_valid;
    nxp_pkg::t_val              r_rd_a;
    nxp_pkg::t_val              r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // unwritten entries hold the identity value
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_valid[i_req.raddr_a] ? r_mem[i_req.raddr_a]
                                         : nxp_pkg::VAL_W'(i_req.raddr_a);
        r_rd_b <= r_valid[i_req.raddr_b] ? r_mem[i_req.raddr_b]
                                         : nxp_pkg::VAL_W'(i_req.raddr_b);
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ design/nxp_seq.sv @@
// Sequencer for the next-permutation step: pivot scan, successor search,
// swap, suffix reversal and emission through one shared comparator.
// Uses nxp_pkg; drives nxp_store through a t_mem_req.
`timescale 1ns / 1ps

module nxp_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_kind,
    input  logic [nxp_pkg::POS_W-1:0]   i_position,
    input  nxp_pkg::t_val               i_value,
    input  logic [nxp_pkg::LEN_W-1:0]   i_len,
    output nxp_pkg::t_mem_req           o_req,
    input  nxp_pkg::t_val               i_rd_a,
    input  nxp_pkg::t_val               i_rd_b,
    output logic                        o_strobe,
    output logic [nxp_pkg::POS_W-1:0]   o_position_res,
    output nxp_pkg::t_val               o_element,
    output logic                        o_last,
    output logic                        o_advanced
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PV_RD  = 4'd1;
    localparam logic [3:0] S_PV_CMP = 4'd2;
    localparam logic [3:0] S_SU_RD  = 4'd3;
    localparam logic [3:0] S_SU_CMP = 4'd4;
    localparam logic [3:0] S_SW_A   = 4'd5;
    localparam logic [3:0] S_SW_B   = 4'd6;
    localparam logic [3:0] S_RV_RD  = 4'd7;
    localparam logic [3:0] S_RV_WA  = 4'd8;
    localparam logic [3:0] S_RV_WB  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]    r_state, n_state;
    nxp_pkg::t_idx r_i, n_i;
    nxp_pkg::t_idx r_j, n_j;
    nxp_pkg::t_idx r_p, n_p;
    nxp_pkg::t_val r_pv, n_pv;
    nxp_pkg::t_val r_tmp, n_tmp;
    logic          r_adv, n_adv;
    logic          r_out_v, n_out_v;
    nxp_pkg::t_idx r_out_pos, n_out_pos;
    logic          r_out_last, n_out_last;

    nxp_pkg::t_idx len_m1;
    nxp_pkg::t_idx len_m2;
    nxp_pkg::t_val cmp_x;
    nxp_pkg::t_val cmp_y;
    logic          cmp_gt;

    assign len_m1 = nxp_pkg::IDX_W'(i_len - nxp_pkg::LEN_W'(1));
    assign len_m2 = nxp_pkg::IDX_W'(i_len - nxp_pkg::LEN_W'(2));

    // shared comparator: pivot scan tests a[i+1] > a[i], search tests a[k] > pivot
    assign cmp_x  = (r_state == S_PV_CMP) ? i_rd_b : i_rd_a;
    assign cmp_y  = (r_state == S_PV_CMP) ? i_rd_a : r_pv;
    assign cmp_gt = cmp_x > cmp_y;

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_p        = r_p;
        n_pv       = r_pv;
        n_tmp      = r_tmp;
        n_adv      = r_adv;
        n_out_v    = 1'b0;
        n_out_pos  = r_out_pos;
        n_out_last = 1'b0;
        o_req      = '{we: 1'b0, waddr: r_i, wdata: r_tmp, raddr_a: r_i, raddr_b: r_j};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == nxp_pkg::KIND_WRITE) begin
                        // drop writes at or beyond the active length
                        o_req.we    = {1'b0, i_position} < i_len;
                        o_req.waddr = nxp_pkg::IDX_W'(i_position);
                        o_req.wdata = i_value;
                    end else begin
                        n_i     = len_m2;
                        n_state = S_PV_RD;
                    end
                end
            end
            S_PV_RD: begin
                o_req.raddr_a = r_i;
                o_req.raddr_b = r_i + nxp_pkg::IDX_W'(1);
                n_state       = S_PV_CMP;
            end
            S_PV_CMP: begin
                if (cmp_gt) begin
                    n_p     = r_i;
                    n_pv    = i_rd_a;
                    n_i     = len_m1;
                    n_adv   = 1'b1;
                    n_state = S_SU_RD;
                end else if (r_i == '0) begin
                    n_adv   = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i - nxp_pkg::IDX_W'(1);
                    n_state = S_PV_RD;
                end
            end
            S_SU_RD: begin
                o_req.raddr_a = r_i;
                n_state       = S_SU_CMP;
            end
            S_SU_CMP: begin
                if (cmp_gt) begin
                    n_tmp   = i_rd_a;
                    n_state = S_SW_A;
                end else begin
                    n_i     = r_i - nxp_pkg::IDX_W'(1);
                    n_state = S_SU_RD;
                end
            end
            S_SW_A: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_p;
                o_req.wdata = r_tmp;
                n_state     = S_SW_B;
            end
            S_SW_B: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_i;
                o_req.wdata = r_pv;
                n_i         = r_p + nxp_pkg::IDX_W'(1);
                n_j         = len_m1;
                if ((r_p + nxp_pkg::IDX_W'(1)) < len_m1) begin
                    n_state = S_RV_RD;
                end else begin
                    n_i     = '0;
                    n_state = S_EMIT;
                end
            end
            S_RV_RD: begin
                o_req.raddr_a = r_i;
                o_req.raddr_b = r_j;
                n_state       = S_RV_WA;
            end
            S_RV_WA: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_i;
                o_req.wdata = i_rd_b;
                n_tmp       = i_rd_a;
                n_state     = S_RV_WB;
            end
            S_RV_WB: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_j;
                o_req.wdata = r_tmp;
                n_i         = r_i + nxp_pkg::IDX_W'(1);
                n_j         = r_j - nxp_pkg::IDX_W'(1);
                if ((r_i + nxp_pkg::IDX_W'(1)) < (r_j - nxp_pkg::IDX_W'(1))) begin
                    n_state = S_RV_RD;
                end else begin
                    n_i     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // read one element a cycle; data shows with the strobe next cycle
                o_req.raddr_a = r_i;
                n_out_v       = 1'b1;
                n_out_pos     = r_i;
                n_out_last    = (r_i == len_m1);
                if (r_i == len_m1) begin
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + nxp_pkg::IDX_W'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
            r_adv      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_v    <= n_out_v;
            r_out_last <= n_out_last;
            r_adv      <= n_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_p       <= n_p;
        r_pv      <= n_pv;
        r_tmp     <= n_tmp;
        r_out_pos <= n_out_pos;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_strobe       = r_out_v;
    assign o_position_res = nxp_pkg::POS_W'(r_out_pos);
    assign o_element      = i_rd_a;
    assign o_last         = r_out_last;
    assign o_advanced     = r_adv;

    a_strobe_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ($past(r_state) == S_EMIT))
        else $error("result strobe without emit cycle");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_last) |=> !r_out_v)
        else $error("result after last element");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_out_v)
        else $error("result strobe while idle");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_A) |-> (r_i > r_p))
        else $error("successor index not right of pivot");

endmodule

@@ design/next_permutation_generator_unit.sv @@
// Top level of the next-permutation generator: length register, active
// length clamp, sequencer and sequence store. Uses nxp_pkg, nxp_seq, nxp_store.
//
// Usage:
//   Request channel: raise start with i_kind/i_position/i_value; the request
//   is taken at a rising edge with start high and busy low.
//   A write request (i_kind 0) stores i_value at i_position in that cycle;
//   busy never rises and no result follows. Writes at or beyond the active
//   length are dropped.
//   An advance request (i_kind 1) steps the sequence to its lexicographic
//   successor and emits one result per element, positions 0..n-1, each on
//   o_res_strobe for one cycle, o_last on the final one. o_advanced is 0 on
//   every result when the sequence was already final.
//   An advance with n elements and pivot p runs a pivot scan, a successor
//   search, a swap of pivot and successor and a pairwise reversal of the
//   suffix (a final sequence goes from the scan straight to emission), then
//   emission, the memory read port setting one element per cycle.
//   Results cannot be held off; the receiver must take each one.
//   Configuration: i_cfg_data is written to the length register when
//   i_cfg_valid is high (o_cfg_ready is always high); write only while idle.
//   Reset: length 16, sequence reads as identity 0,1,2,...
`timescale 1ns / 1ps

module next_permutation_generator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [nxp_pkg::POS_W-1:0]     i_position,
    input  logic [nxp_pkg::VAL_W-1:0]     i_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nxp_pkg::LEN_W-1:0]     i_cfg_data,
    output logic                          o_res_strobe,
    output logic [nxp_pkg::POS_W-1:0]     o_position_res,
    output logic [nxp_pkg::VAL_W-1:0]     o_element,
    output logic                          o_last,
    output logic                          o_advanced
);

    logic [nxp_pkg::LEN_W-1:0] r_len;
    logic [nxp_pkg::LEN_W-1:0] len_act;
    nxp_pkg::t_mem_req         mem_req;
    nxp_pkg::t_val             rd_a;
    nxp_pkg::t_val             rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= nxp_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamp the register into the supported length range
    assign len_act = (r_len < nxp_pkg::LEN_MIN) ? nxp_pkg::LEN_MIN :
                     (r_len > nxp_pkg::LEN_MAX) ? nxp_pkg::LEN_MAX : r_len;

    nxp_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_value        (i_value),
        .i_len          (len_act),
        .o_req          (mem_req),
        .i_rd_a         (rd_a),
        .i_rd_b         (rd_b),
        .o_strobe       (o_res_strobe),
        .o_position_res (o_position_res),
        .o_element      (o_element),
        .o_last         (o_last),
        .o_advanced     (o_advanced)
    );

    nxp_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

endmodule

@@ tb/sv/nxp_perm_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for next_permutation_generator_unit: follows the length register
// and the sequence from accepted requests, predicts each emitted element and
// compares it with the result port. Depends on nxp_pkg.

module nxp_perm_checker
    import nxp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             i_kind,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             o_res_strobe,
    input  logic [POS_W-1:0] o_position_res,
    input  logic [VAL_W-1:0] o_element,
    input  logic             o_last,
    input  logic             o_advanced,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen,
    output int               o_finals_seen
);

    localparam int EMIT_CAP = 16;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] elem;
        logic             tail;
        logic             adv;
    } t_emit;

    t_val             perm_seq [MAX_LEN];
    logic [LEN_W-1:0] len_reg;
    t_emit            due_elements [$];

    function automatic int active_count(input logic [LEN_W-1:0] r);
        int n;
        n = int'(r);
        if (n < 2) n = 2;
        if (n > MAX_LEN) n = MAX_LEN;
        if (n > EMIT_CAP) n = EMIT_CAP;
        return n;
    endfunction

    // Step the first n entries to their lexicographic successor in place.
    function automatic bit step_to_successor(input int n);
        int   piv;
        int   k;
        int   lo;
        int   hi;
        t_val t;
        piv = n - 2;
        while (piv >= 0 && perm_seq[piv] >= perm_seq[piv + 1]) piv--;
        if (piv < 0) return 1'b0;
        k = n - 1;
        while (perm_seq[k] <= perm_seq[piv]) k--;
        t = perm_seq[piv];
        perm_seq[piv] = perm_seq[k];
        perm_seq[k] = t;
        lo = piv + 1;
        hi = n - 1;
        while (lo < hi) begin
            t = perm_seq[lo];
            perm_seq[lo] = perm_seq[hi];
            perm_seq[hi] = t;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_emit want;
        t_emit item;
        int    n;
        bit    moved;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEN; i++) perm_seq[i] = t_val'(i);
            len_reg = LEN_RESET;
            due_elements.delete();
        end else begin
            // Results come from earlier requests: compare before taking a new one.
            if (o_res_strobe === 1'b1) begin
                o_results_seen++;
                if (due_elements.size() == 0) begin
                    $error("unexpected result: position_res %0d, element %0d",
                           o_position_res, o_element);
                    o_fail_count++;
                end else begin
                    want = due_elements.pop_front();
                    if (o_position_res !== want.pos) begin
                        $error("position_res: expected %0d, got %0d", want.pos, o_position_res);
                        o_fail_count++;
                    end
                    if (o_element !== want.elem) begin
                        $error("element: expected %0d, got %0d", want.elem, o_element);
                        o_fail_count++;
                    end
                    if (o_last !== want.tail) begin
                        $error("last: expected %0d, got %0d", want.tail, o_last);
                        o_fail_count++;
                    end
                    if (o_advanced !== want.adv) begin
                        $error("advanced: expected %0d, got %0d", want.adv, o_advanced);
                        o_fail_count++;
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready) len_reg = i_cfg_data;

            if (start && !busy) begin
                n = active_count(len_reg);
                if (i_kind == KIND_WRITE) begin
                    // drop writes at or past the active length
                    if (int'(i_position) < n) perm_seq[i_position] = i_value;
                end else begin
                    moved = step_to_successor(n);
                    if (!moved) o_finals_seen++;
                    for (int k = 0; k < n; k++) begin
                        item.pos  = POS_W'(k);
                        item.elem = perm_seq[k];
                        item.tail = (k == n - 1);
                        item.adv  = moved;
                        due_elements.push_back(item);
                    end
                end
            end
        end
        o_pending = due_elements.size();
    end

endmodule

@@ tb/sv/tb_next_permutation_generator_unit.sv @@
`timescale 1ns / 1ps
// Top of the next-permutation generator testbench: clock, reset, request and
// length stimulus, verdict. Depends on nxp_pkg, nxp_perm_checker and the DUT.

module tb_next_permutation_generator_unit;
    import nxp_pkg::*;

    localparam int SETTLE_CYCLES = 16;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             i_kind      = KIND_WRITE;
    logic [POS_W-1:0] i_position  = '0;
    logic [VAL_W-1:0] i_value     = '0;
    logic             i_cfg_valid = 1'b0;
    logic [LEN_W-1:0] i_cfg_data  = '0;
    logic             busy;
    logic             o_cfg_ready;
    logic             o_res_strobe;
    logic [POS_W-1:0] o_position_res;
    logic [VAL_W-1:0] o_element;
    logic             o_last;
    logic             o_advanced;

    int fail_count;
    int pending;
    int results_seen;
    int finals_seen;

    int idle_pct   = 0;
    int cur_len    = 16;
    int requests   = 0;
    int advances   = 0;
    int cfg_writes = 0;

    always #1 i_clk = ~i_clk;

    next_permutation_generator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_value        (i_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_res_strobe   (o_res_strobe),
        .o_position_res (o_position_res),
        .o_element      (o_element),
        .o_last         (o_last),
        .o_advanced     (o_advanced)
    );

    nxp_perm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_value        (i_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_res_strobe   (o_res_strobe),
        .o_position_res (o_position_res),
        .o_element      (o_element),
        .o_last         (o_last),
        .o_advanced     (o_advanced),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_finals_seen  (finals_seen)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    // busy only moves at rising edges, so its value here holds through the next one.
    task automatic send(input logic k, input int pos, input int val);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= k;
        i_position <= POS_W'(pos);
        i_value    <= VAL_W'(val);
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        if (k == KIND_ADVANCE) advances++;
        if (k == KIND_ADVANCE || pos < cur_len) requests++;
    endtask

    // Hold off requests until every predicted element has come out.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_len = (v < LEN_MIN) ? 2 : (v > LEN_MAX) ? MAX_LEN : int'(v);
        cfg_writes++;
    endtask

    // Load all active entries: small alphabet (repeats), full range, or non-increasing.
    task automatic fill_sequence(input int style);
        int vals [MAX_LEN];
        int order [MAX_LEN];
        int alpha;
        int base;
        int cur;
        int j;
        int t;
        alpha = $urandom_range(1, 4);
        base  = $urandom_range(0, 252);
        cur   = $urandom_range(255);
        for (int i = 0; i < cur_len; i++) begin
            order[i] = i;
            case (style)
                0: vals[i] = base + $urandom_range(alpha - 1);
                1: vals[i] = $urandom_range(255);
                default: begin
                    vals[i] = cur;
                    cur = cur - $urandom_range(0, (cur > 3) ? 3 : cur);
                end
            endcase
        end
        for (int i = cur_len - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < cur_len; i++) begin
            if ($urandom_range(9) == 0) send(KIND_WRITE, $urandom_range(15), $urandom_range(255));
            send(KIND_WRITE, order[i], vals[order[i]]);
        end
    endtask

    task automatic run_block();
        logic [LEN_W-1:0] v;
        int               r;
        int               steps;
        r = $urandom_range(99);
        if (r < 55)      v = LEN_W'($urandom_range(2, 5));
        else if (r < 70) v = LEN_W'($urandom_range(6, 15));
        else if (r < 82) v = LEN_MAX;
        else if (r < 91) v = LEN_W'($urandom_range(17, 31));
        else             v = LEN_W'($urandom_range(1));
        set_length(v);
        if ($urandom_range(3) != 0) fill_sequence($urandom_range(2));
        // short sequences get more steps, so they can run into the final order
        steps = $urandom_range(1, (cur_len <= 4) ? 9 : 4);
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(9) == 0) send(KIND_WRITE, $urandom_range(15), $urandom_range(255));
            send(KIND_ADVANCE, $urandom_range(15), $urandom_range(255));
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity start, field extremes at full length
        send(KIND_ADVANCE, 0, 0);
        send(KIND_WRITE, 15, 255);
        send(KIND_WRITE, 0, 0);
        send(KIND_ADVANCE, 15, 255);
        send(KIND_ADVANCE, 0, 0);
        // length below range, dropped write, already-final order
        set_length(0);
        send(KIND_WRITE, 5, 7);
        send(KIND_WRITE, 0, 200);
        send(KIND_WRITE, 1, 100);
        send(KIND_ADVANCE, 0, 0);
        send(KIND_ADVANCE, 0, 0);
        send(KIND_WRITE, 15, 1);
        // all equal values
        set_length(3);
        send(KIND_WRITE, 0, 9);
        send(KIND_WRITE, 1, 9);
        send(KIND_WRITE, 2, 9);
        send(KIND_ADVANCE, 0, 0);
        // lengths above and below range
        set_length(17);
        send(KIND_ADVANCE, 0, 0);
        set_length(1);
        send(KIND_WRITE, 0, 0);
        send(KIND_WRITE, 1, 255);
        send(KIND_ADVANCE, 0, 0);
        send(KIND_ADVANCE, 0, 0);
        set_length(31);
        send(KIND_ADVANCE, 0, 0);

        idle_pct = 31;
        while (requests < 140) run_block();
        idle_pct = 83;
        while (requests < 250) run_block();
        idle_pct = 0;
        while (requests < 360) run_block();

        drain();
        $display("Sent %0d requests (%0d advances) over %0d length settings.",
                 requests, advances, cfg_writes);
        $display("Checked %0d elements; %0d advances met an already-final sequence.",
                 results_seen, finals_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
